FILE: hdl/tprs_pkg.sv
package tprs_pkg;

  // time unit codes of a request
  localparam logic [1:0] UNIT_NONE = 2'd0;
  localparam logic [1:0] UNIT_S    = 2'd1;
  localparam logic [1:0] UNIT_MS   = 2'd2;
  localparam logic [1:0] UNIT_US   = 2'd3;

  // result source codes
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_MANUAL = 2'd1;
  localparam logic [1:0] SRC_PERIOD = 2'd2;
  localparam logic [1:0] SRC_FREQ   = 2'd3;

  // configuration register indexes
  localparam logic CFG_CLOCK = 1'b0;
  localparam logic CFG_WIDE  = 1'b1;

  localparam logic [31:0] CLOCK_RESET_HZ = 32'd84000000;

  // factor select, stripped in this order
  localparam logic [1:0] FSEL_5 = 2'd0;
  localparam logic [1:0] FSEL_3 = 2'd1;
  localparam logic [1:0] FSEL_2 = 2'd2;

  // 1000000 / freq: dividend fits in 20 bits
  localparam int unsigned DIV_BITS = 20;
  localparam logic [DIV_BITS-1:0] DIV_DIVIDEND = 20'd1000000;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

  typedef struct packed {
    logic       start;
    logic       use_freq;
    logic [1:0] unit;
  } solve_req_t;

  // reciprocal multiplier for clk / u (exact for all 32-bit clk)
  function automatic logic [31:0] unit_recip(input logic [1:0] unit);
    logic [31:0] r;
    unique case (unit)
      UNIT_MS: r = 32'h10624DD3;
      UNIT_US: r = 32'h431BDE83;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] unit_quot(input logic [63:0] prod, input logic [1:0] unit);
    logic [31:0] q;
    unique case (unit)
      UNIT_MS: q = 32'(prod[63:38]);
      UNIT_US: q = 32'(prod[63:50]);
      default: q = prod[31:0];
    endcase
    return q;
  endfunction

  function automatic logic [31:0] unit_value(input logic [1:0] unit);
    logic [31:0] v;
    unique case (unit)
      UNIT_MS: v = 32'd1000;
      UNIT_US: v = 32'd1000000;
      default: v = 32'd1;
    endcase
    return v;
  endfunction

  // reciprocal multiplier for q / f, f in 5, 3, 2
  function automatic logic [31:0] fac_recip(input logic [1:0] fsel);
    logic [31:0] r;
    unique case (fsel)
      FSEL_5:  r = 32'hCCCCCCCD;
      FSEL_3:  r = 32'hAAAAAAAB;
      default: r = 32'h80000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] fac_quot(input logic [63:0] prod, input logic [1:0] fsel);
    logic [31:0] q;
    unique case (fsel)
      FSEL_5:  q = 32'(prod[63:34]);
      FSEL_3:  q = 32'(prod[63:33]);
      default: q = prod[63:32];
    endcase
    return q;
  endfunction

  function automatic logic [31:0] fac_times(input logic [31:0] x, input logic [1:0] fsel);
    logic [31:0] p;
    unique case (fsel)
      FSEL_5:  p = (x << 2) + x;
      FSEL_3:  p = (x << 1) + x;
      default: p = x << 1;
    endcase
    return p;
  endfunction

  // prescaler limit divided by the factor
  function automatic logic [31:0] fac_limit(input logic [1:0] fsel, input logic wide);
    logic [31:0] l;
    unique case (fsel)
      FSEL_5:  l = wide ? 32'd858993459  : 32'd13107;
      FSEL_3:  l = wide ? 32'd1431655765 : 32'd21845;
      default: l = wide ? 32'd2147483647 : 32'd32767;
    endcase
    return l;
  endfunction

endpackage

FILE: hdl/tprs_div.sv
module tprs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   divisor_i,
  output logic                          done_o,
  output logic [tprs_pkg::DIV_BITS-1:0] quot_o
);
  import tprs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          rem_q, rem_d;
  logic [31:0]          dvs_q, dvs_d;
  logic [DIV_BITS-1:0]  quo_q, quo_d;
  logic [DIV_CNT_W-1:0] bit_idx;
  logic [32:0]          trial;
  logic                 last;

  // restoring division of a constant dividend, one bit per cycle
  always_comb begin
    bit_idx = DIV_CNT_W'(DIV_BITS - 1) - cnt_q;
    trial   = {rem_q, DIV_DIVIDEND[bit_idx]};
    last    = (cnt_q == DIV_CNT_W'(DIV_BITS - 1));
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 32'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[DIV_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: hdl/tprs_solver.sv
module tprs_solver (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tprs_pkg::solve_req_t req_i,
  input  logic [31:0]          period_i,
  input  logic [31:0]          freq_i,
  input  logic [31:0]          clock_hz_i,
  input  logic                 wide_i,
  output logic                 done_o,
  output logic [31:0]          psc_o,
  output logic [31:0]          cnt_o
);
  import tprs_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV      = 3'd1;
  localparam logic [2:0] ST_INIT_MUL = 3'd2;
  localparam logic [2:0] ST_INIT_CHK = 3'd3;
  localparam logic [2:0] ST_STEP_A   = 3'd4;
  localparam logic [2:0] ST_STEP_B   = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [1:0]  fsel_q, fsel_d;
  logic [1:0]  unit_q, unit_d;
  logic [31:0] period_q, period_d;
  logic [31:0] q_q, q_d;        // clk / u
  logic [31:0] quot_q, quot_d;  // q / f candidate
  logic [31:0] psc_q, psc_d;
  logic [31:0] cnt_q, cnt_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_done;
  logic [DIV_BITS-1:0] div_quot;
  logic        step_ok;

  tprs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (req_i.start && req_i.use_freq && (state_q == ST_IDLE)),
    .divisor_i (freq_i),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // the one shared multiplier
  always_comb begin
    unique case (state_q)
      ST_INIT_MUL: begin
        mul_a = clock_hz_i;
        mul_b = unit_recip(unit_q);
      end
      ST_INIT_CHK: begin
        mul_a = q_q;
        mul_b = unit_value(unit_q);
      end
      ST_STEP_A: begin
        mul_a = q_q;
        mul_b = fac_recip(fsel_q);
      end
      default: begin
        mul_a = quot_q;
        mul_b = period_q;
      end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // factor divides q, prescaler stays below limit, factor 2 keeps count above one
  assign step_ok = (fac_times(quot_q, fsel_q) == q_q)
                && (psc_q < fac_limit(fsel_q, wide_i))
                && ((fsel_q != FSEL_2) || (prod[31:0] > 32'd1));

  always_comb begin
    state_d  = state_q;
    fsel_d   = fsel_q;
    unit_d   = unit_q;
    period_d = period_q;
    q_d      = q_q;
    quot_d   = quot_q;
    psc_d    = psc_q;
    cnt_d    = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          psc_d    = 32'd1;
          cnt_d    = 32'd1;
          fsel_d   = FSEL_5;
          period_d = period_i;
          unit_d   = req_i.use_freq ? UNIT_US : req_i.unit;
          state_d  = req_i.use_freq ? ST_DIV : ST_INIT_MUL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          period_d = 32'(div_quot);
          state_d  = ST_INIT_MUL;
        end
      end
      ST_INIT_MUL: begin
        q_d     = unit_quot(prod, unit_q);
        state_d = ST_INIT_CHK;
      end
      ST_INIT_CHK: begin
        // clk not a multiple of u: no factor can ever be taken
        state_d = (prod[31:0] == clock_hz_i) ? ST_STEP_A : ST_DONE;
      end
      ST_STEP_A: begin
        quot_d  = fac_quot(prod, fsel_q);
        state_d = ST_STEP_B;
      end
      ST_STEP_B: begin
        if (step_ok) begin
          q_d     = quot_q;
          psc_d   = fac_times(psc_q, fsel_q);
          cnt_d   = prod[31:0];
          state_d = ST_STEP_A;
        end else if (fsel_q == FSEL_2) begin
          state_d = ST_DONE;
        end else begin
          fsel_d  = fsel_q + 2'd1;
          state_d = ST_STEP_A;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fsel_q  <= FSEL_5;
    end else begin
      state_q <= state_d;
      fsel_q  <= fsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q   <= unit_d;
    period_q <= period_d;
    q_q      <= q_d;
    quot_q   <= quot_d;
    psc_q    <= psc_d;
    cnt_q    <= cnt_d;
  end

  assign done_o = (state_q == ST_DONE);
  assign psc_o  = psc_q;
  assign cnt_o  = cnt_q;

endmodule

FILE: hdl/timer_prescaler_reload_solver.sv
// Timer prescaler / reload solver.
// Input channel (in_valid_i / in_ready_o): one request per transfer. A manual
// pair (both nonzero) wins, then a period with a time unit, then a target
// frequency. Output channel (out_valid_o / out_ready_i): one result per
// request, carrying the held prescaler and reload values, the source used and
// the preload flag.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0: timer clock in Hz, 1: wide prescaler limit). Write only while idle.
// Manual or no-source requests give a result in the cycle after the transfer.
// A period solve finds clock / unit, ends with no factor taken when the clock
// is not a multiple of the unit, else strips factors 5, 3, 2; every step is
// two passes through the one shared 32x32 multiplier. A frequency solve first
// runs the bit-serial 1000000 / frequency divider.
// One request is in flight at a time; in_ready_o is low while solving.
// The result sits in the output register until taken; a new request is
// accepted in the same cycle the old result transfers.
// Reset: clock register 84 MHz, narrow limit, held values zero, no result.
module timer_prescaler_reload_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] manual_prescale_i,
  input  logic [31:0] manual_reload_i,
  input  logic [31:0] period_amount_i,
  input  logic [1:0]  time_unit_i,
  input  logic [31:0] target_freq_hz_i,
  input  logic        preload_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] prescale_reg_o,
  output logic [31:0] reload_reg_o,
  output logic [1:0]  value_source_o,
  output logic        preload_on_o
);
  import tprs_pkg::*;

  logic [31:0] clock_hz_q;
  logic        wide_q;
  logic [31:0] held_psc_q, held_psc_d;
  logic [31:0] held_rld_q, held_rld_d;
  logic        busy_q, busy_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  src_q, src_d;
  logic        pre_q, pre_d;

  logic        in_fire;
  logic        is_manual, is_period, is_freq;
  solve_req_t  req;
  logic        sol_done;
  logic [31:0] sol_psc, sol_cnt;

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_manual = (manual_prescale_i != 32'd0) && (manual_reload_i != 32'd0);
  assign is_period = (period_amount_i != 32'd0) && (time_unit_i != UNIT_NONE);
  assign is_freq   = (target_freq_hz_i != 32'd0);

  always_comb begin
    req.start    = in_fire && !is_manual && (is_period || is_freq);
    req.use_freq = !is_period;
    req.unit     = time_unit_i;
  end

  tprs_solver u_solver (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .period_i   (period_amount_i),
    .freq_i     (target_freq_hz_i),
    .clock_hz_i (clock_hz_q),
    .wide_i     (wide_q),
    .done_o     (sol_done),
    .psc_o      (sol_psc),
    .cnt_o      (sol_cnt)
  );

  always_comb begin
    held_psc_d  = held_psc_q;
    held_rld_d  = held_rld_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    src_d       = src_q;
    pre_d       = pre_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      pre_d = preload_request_i;
      if (is_manual) begin
        held_psc_d  = manual_prescale_i - 32'd1;
        held_rld_d  = manual_reload_i - 32'd1;
        src_d       = SRC_MANUAL;
        out_valid_d = 1'b1;
      end else if (is_period) begin
        src_d  = SRC_PERIOD;
        busy_d = 1'b1;
      end else if (is_freq) begin
        src_d  = SRC_FREQ;
        busy_d = 1'b1;
      end else begin
        // nothing given: held values stay
        src_d       = SRC_NONE;
        out_valid_d = 1'b1;
      end
    end
    if (sol_done) begin
      held_psc_d  = sol_psc - 32'd1;
      held_rld_d  = sol_cnt - 32'd1;  // count of zero wraps
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q  <= CLOCK_RESET_HZ;
      wide_q      <= 1'b0;
      held_psc_q  <= '0;
      held_rld_q  <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      src_q       <= SRC_NONE;
      pre_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CLOCK: clock_hz_q <= cfg_data_i;
          CFG_WIDE:  wide_q     <= cfg_data_i[0];
          default:   ;
        endcase
      end
      held_psc_q  <= held_psc_d;
      held_rld_q  <= held_rld_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      src_q       <= src_d;
      pre_q       <= pre_d;
    end
  end

  // held values stay put while a result waits, so they drive the port directly
  assign out_valid_o    = out_valid_q;
  assign prescale_reg_o = held_psc_q;
  assign reload_reg_o   = held_rld_q;
  assign value_source_o = src_q;
  assign preload_on_o   = pre_q && (held_psc_q != 32'd0) && (held_rld_q != 32'd0);

  a_busy_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o)
    else $error("request taken while solving");

  a_done_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sol_done |-> busy_q && !out_valid_q)
    else $error("solver finished with no request pending");

  a_manual_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_manual) |=> out_valid_o && (value_source_o == SRC_MANUAL))
    else $error("manual result not presented next cycle");

  a_solve_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (src_q == SRC_PERIOD) || (src_q == SRC_FREQ))
    else $error("solver running for a non-solve source");

endmodule

FILE: verif/timer_prescaler_reload_solver_test.sv
`timescale 1ns / 1ps

module timer_prescaler_reload_solver_test;
  import tprs_pkg::*;

  // run shape
  localparam int PHASES       = 7;      // config settings after the directed part
  localparam int PHASE_ITEMS  = 64;     // random requests per setting
  localparam int SETTLE_CYC   = 64;     // quiet cycles after the last result
  localparam int HOLD_CYC     = 200;    // one long output stall to back up the input
  localparam int HOLD_AFTER   = 40;     // results seen before that stall starts
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [31:0] mp;
    logic [31:0] mr;
    logic [31:0] per;
    logic [1:0]  tunit;
    logic [31:0] freq;
    logic        pre;
  } timer_req_t;

  typedef struct {
    logic [31:0] psc;
    logic [31:0] arr;
    logic [1:0]  src;
    logic        pre_on;
  } timer_regs_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic        cfg_idx_i         = CFG_CLOCK;
  logic [31:0] cfg_data_i        = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [31:0] manual_prescale_i = '0;
  logic [31:0] manual_reload_i   = '0;
  logic [31:0] period_amount_i   = '0;
  logic [1:0]  time_unit_i       = UNIT_NONE;
  logic [31:0] target_freq_hz_i  = '0;
  logic        preload_request_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [31:0] prescale_reg_o;
  logic [31:0] reload_reg_o;
  logic [1:0]  value_source_o;
  logic        preload_on_o;

  timer_prescaler_reload_solver u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .manual_prescale_i (manual_prescale_i),
    .manual_reload_i   (manual_reload_i),
    .period_amount_i   (period_amount_i),
    .time_unit_i       (time_unit_i),
    .target_freq_hz_i  (target_freq_hz_i),
    .preload_request_i (preload_request_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .prescale_reg_o    (prescale_reg_o),
    .reload_reg_o      (reload_reg_o),
    .value_source_o    (value_source_o),
    .preload_on_o      (preload_on_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the config registers and the held
  // prescaler / reload pair. Config copy is only touched while the DUT idles.
  // ---------------------------------------------------------------------------
  logic [31:0] clock_hz_cfg = CLOCK_RESET_HZ;
  logic        wide_cfg     = 1'b0;
  logic [31:0] pred_psc     = '0;
  logic [31:0] pred_arr     = '0;

  timer_req_t  req_fifo[$];       // requests waiting for the driver
  timer_regs_t regs_fifo[$];      // predicted results, oldest first
  timer_req_t  cur_req;           // request on the input port

  int  n_queued      = 0;
  int  n_accepted    = 0;
  int  n_results     = 0;
  int  n_errors      = 0;
  int  n_settings    = 0;
  int  src_seen[4]   = '{default: 0};
  int  in_stall_cyc  = 0;
  int  cycle_cnt     = 0;
  int  send_gap      = 0;
  int  ready_gap     = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  bit  quiet         = 1'b0;      // no idling on either side in the last phase

  // Strip 5s, then 3s, then 2s from the timer clock while the divided clock
  // still gives whole ticks per time unit and the prescaler stays in range.
  // Products wrap at 32 bits, as does count - 1 (count 0 -> all ones).
  function automatic void strip_factors(input logic [31:0] per, input logic [1:0] tunit);
    logic [31:0] u;
    logic [31:0] lim;
    logic [31:0] clk;
    logic [31:0] psc;
    logic [31:0] cnt;
    logic [31:0] f;
    logic [31:0] half_cnt;
    bit          go;
    int          k;
    u   = (tunit == UNIT_S) ? 32'd1 : (tunit == UNIT_MS) ? 32'd1000 : 32'd1000000;
    lim = wide_cfg ? 32'hFFFF_FFFF : 32'd65535;
    clk = clock_hz_cfg;
    psc = 32'd1;
    cnt = 32'd1;
    for (k = 0; k < 3; k++) begin
      f  = (k == 0) ? 32'd5 : (k == 1) ? 32'd3 : 32'd2;
      go = 1'b1;
      while (go) begin
        half_cnt = (clk / (32'd2 * u)) * per;
        if ((clk % f) != 0 || ((clk / f) % u) != 0 || psc >= lim / f) begin
          go = 1'b0;
        end else if (f == 32'd2 && half_cnt <= 32'd1) begin
          go = 1'b0;
        end else begin
          clk = clk / f;
          psc = psc * f;
          cnt = (clk / u) * per;
        end
      end
    end
    pred_psc = psc - 32'd1;
    pred_arr = cnt - 32'd1;
  endfunction

  // Source priority: manual pair, period + unit, frequency, else hold.
  function automatic timer_regs_t predict_timer_regs(input timer_req_t r);
    timer_regs_t res;
    res.src = SRC_NONE;
    if (r.mp != 0 && r.mr != 0) begin
      pred_psc = r.mp - 32'd1;
      pred_arr = r.mr - 32'd1;
      res.src  = SRC_MANUAL;
    end else if (r.per != 0 && r.tunit != UNIT_NONE) begin
      strip_factors(r.per, r.tunit);
      res.src = SRC_PERIOD;
    end else if (r.freq != 0) begin
      strip_factors(32'd1000000 / r.freq, UNIT_US);
      res.src = SRC_FREQ;
    end
    res.psc    = pred_psc;
    res.arr    = pred_arr;
    res.pre_on = r.pre && pred_psc != 0 && pred_arr != 0;
    return res;
  endfunction

  task automatic add_req(input logic [31:0] mp, input logic [31:0] mr, input logic [31:0] per,
                         input logic [1:0] tunit, input logic [31:0] freq, input logic pre);
    timer_req_t r;
    r = '{mp: mp, mr: mr, per: per, tunit: tunit, freq: freq, pre: pre};
    req_fifo.push_back(r);
    n_queued++;
  endtask

  // Mostly well-formed requests aimed at one source, the rest pure noise.
  function automatic timer_req_t random_request();
    timer_req_t r;
    int         kind;
    kind    = $urandom_range(0, 99);
    r.mp    = $urandom;
    r.mr    = $urandom;
    r.per   = $urandom;
    r.tunit = 2'($urandom_range(0, 3));
    r.freq  = $urandom;
    r.pre   = 1'($urandom_range(0, 1));
    if (kind < 25) begin
      if ($urandom_range(0, 1) == 1) begin
        r.mp = $urandom_range(0, 70000);
        r.mr = $urandom_range(0, 70000);
      end
    end else if (kind < 85) begin
      if ($urandom_range(0, 1) == 1) r.mp = '0;
      else r.mr = '0;
      if (kind < 55) begin
        r.tunit = 2'($urandom_range(1, 3));
        case ($urandom_range(0, 2))
          0: r.per = $urandom_range(1, 20);
          1: r.per = $urandom_range(1, 100000);
          default: ;
        endcase
      end else begin
        if ($urandom_range(0, 1) == 1) r.per = '0;
        else r.tunit = UNIT_NONE;
        case ($urandom_range(0, 3))
          0: r.freq = $urandom_range(1, 1000);
          1: r.freq = $urandom_range(1, 1000000);
          2: r.freq = $urandom_range(1000001, 2000000);
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  // Clock built from small factors so the solver actually strips something;
  // an occasional 7 is a factor that no step strips.
  function automatic logic [31:0] smooth_clock();
    logic [63:0] c;
    logic [63:0] f;
    int          i;
    case ($urandom_range(0, 2))
      0: c = 64'd1;
      1: c = 64'd1000;
      default: c = 64'd1000000;
    endcase
    for (i = 0; i < 30; i++) begin
      case ($urandom_range(0, 6))
        0, 1: f = 64'd2;
        2, 3: f = 64'd3;
        4, 5: f = 64'd5;
        default: f = 64'd7;
      endcase
      if (c * f <= 64'hFFFF_FFFF) c = c * f;
    end
    return c[31:0];
  endfunction

  // Both registers written back to back; upper bits of the limit write are junk.
  task automatic apply_config(input logic [31:0] clock_hz, input logic wide);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CLOCK;
    cfg_data_i <= clock_hz;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WIDE;
    cfg_data_i <= {31'($urandom), wide};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    clock_hz_cfg = clock_hz;
    wide_cfg     = wide;
    n_settings++;
  endtask

  // Idle means every queued request transferred and every result returned.
  task automatic wait_idle();
    while (n_accepted != n_queued || regs_fifo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers requests from req_fifo, predicts on each transfer.
  // Valid holds with a stable payload until the transfer happens.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        regs_fifo.push_back(predict_timer_regs(cur_req));
        n_accepted++;
      end
      if (in_valid_i && !in_ready_o) begin
        in_stall_cyc++;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        send_gap   = $urandom_range(0, 2);   // start an idle burst of random length
        in_valid_i <= 1'b0;
      end else if (req_fifo.size() != 0) begin
        cur_req = req_fifo.pop_front();
        manual_prescale_i <= cur_req.mp;
        manual_reload_i   <= cur_req.mr;
        period_amount_i   <= cur_req.per;
        time_unit_i       <= cur_req.tunit;
        target_freq_hz_i  <= cur_req.freq;
        preload_request_i <= cur_req.pre;
        in_valid_i        <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver ready: short random stalls plus one long hold-off so the DUT's
  // output register fills and in_ready_o drops while requests keep coming.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && !quiet && n_results >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        hold_left   = HOLD_CYC - 1;
        out_ready_i <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        ready_gap   = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: every result transfer checked field by field against the oldest
  // prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (regs_fifo.size() == 0) begin
        $error("result transfer with no request outstanding");
        n_errors++;
      end else begin
        if (prescale_reg_o !== regs_fifo[0].psc) begin
          $error("prescale_reg: expected %h, got %h", regs_fifo[0].psc, prescale_reg_o);
          n_errors++;
        end
        if (reload_reg_o !== regs_fifo[0].arr) begin
          $error("reload_reg: expected %h, got %h", regs_fifo[0].arr, reload_reg_o);
          n_errors++;
        end
        if (value_source_o !== regs_fifo[0].src) begin
          $error("value_source: expected %0d, got %0d", regs_fifo[0].src, value_source_o);
          n_errors++;
        end
        if (preload_on_o !== regs_fifo[0].pre_on) begin
          $error("preload_on: expected %0b, got %0b", regs_fifo[0].pre_on, preload_on_o);
          n_errors++;
        end
        src_seen[regs_fifo[0].src]++;
        void'(regs_fifo.pop_front());
      end
      n_results++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed requests at reset config, then random phases,
  // each under a fresh clock / limit setting written while idle.
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] ph_clock;
    logic        ph_wide;
    int          ph;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, 84 MHz narrow limit
    add_req('0, '0, '0, UNIT_NONE, '0, 1'b1);                    // nothing, held zero
    add_req(32'd1, 32'd1, '0, UNIT_NONE, '0, 1'b1);              // manual minimum
    add_req('1, '1, '0, UNIT_NONE, '0, 1'b1);                    // manual maximum
    add_req('0, '0, 32'd77, UNIT_NONE, '0, 1'b1);                // period w/o unit: holds
    add_req('0, 32'd5, '0, UNIT_US, '0, 1'b0);                   // unit w/o period: holds
    add_req('0, '0, 32'd1, UNIT_S, '0, 1'b1);
    add_req('0, '0, 32'd1, UNIT_MS, '0, 1'b0);
    add_req('0, '0, 32'd1, UNIT_US, '0, 1'b1);                   // 2s stop at count 7, prescaler 12
    add_req('0, '0, 32'd500, UNIT_MS, '0, 1'b1);
    add_req('0, '0, '1, UNIT_S, '0, 1'b0);                       // count wraps
    add_req('0, '0, '1, UNIT_US, '0, 1'b1);
    add_req(32'd7, '0, '0, UNIT_NONE, 32'd1, 1'b1);              // one-second period
    add_req('0, '0, '0, UNIT_NONE, 32'd1000000, 1'b1);           // period of 1 us
    add_req('0, '0, '0, UNIT_NONE, 32'd1000001, 1'b1);           // period 0, reload all ones
    add_req('0, '0, '0, UNIT_NONE, '1, 1'b0);
    add_req('0, '0, '0, UNIT_NONE, 32'd50, 1'b1);
    add_req('0, 32'd9, 32'd10, UNIT_MS, 32'd400, 1'b1);          // period beats frequency
    add_req(32'd3, '0, '0, UNIT_S, 32'd1000, 1'b0);              // unit w/o period -> freq
    add_req('1, '1, '1, UNIT_US, '1, 1'b1);                      // manual beats all
    add_req(32'd1, 32'd2, '0, UNIT_NONE, '0, 1'b1);              // prescale 0 -> no preload
    add_req('0, '0, '0, UNIT_NONE, '0, 1'b1);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin ph_clock = '0;           ph_wide = 1'b1; end   // zero clock, wide
        1: begin ph_clock = 32'd1;        ph_wide = 1'b0; end
        2: begin ph_clock = '1;           ph_wide = 1'b1; end
        3: begin ph_clock = $urandom;     ph_wide = 1'b0; end
        4: begin ph_clock = smooth_clock(); ph_wide = 1'b0; end
        5: begin ph_clock = smooth_clock(); ph_wide = 1'b1; end
        default: begin ph_clock = smooth_clock(); ph_wide = 1'($urandom_range(0, 1)); end
      endcase
      apply_config(ph_clock, ph_wide);
      if (ph == PHASES - 1) quiet = 1'b1;
      @(negedge clk_i);
      repeat (PHASE_ITEMS) begin
        req_fifo.push_back(random_request());
        n_queued++;
      end
      wait_idle();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Ran %0d requests, %0d settings; hold %0d, manual %0d, period %0d, freq %0d",
             n_accepted, n_settings, src_seen[SRC_NONE], src_seen[SRC_MANUAL],
             src_seen[SRC_PERIOD], src_seen[SRC_FREQ]);
    $display("Input back-pressure seen for %0d cycles, one %0d-cycle output hold-off",
             in_stall_cyc, HOLD_CYC);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
